### hdl/ctb_pkg.sv
// ----------------------------------------------------------------------------
// ctb_pkg - shared types and constants of the cursor text buffer
// command and status codes, stream widths and the result layout
// ----------------------------------------------------------------------------
package ctb_pkg;

  // default number of characters held
  localparam int CAPACITY_DEF = 1024;

  // fixed field widths of the request and result streams
  localparam int CMD_W    = 3;
  localparam int CHAR_W   = 8;
  localparam int POS_W    = 10;
  localparam int CNT_OUT_W = 11;
  localparam int STAT_W   = 2;

  localparam int IN_W  = 24;  // 21 payload bits padded to whole bytes
  localparam int OUT_W = 32;

  // command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LEFT   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RIGHT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_IGNORED = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE   = 2'd3;

  // result word, char_out in the lowest bits
  typedef struct packed {
    logic [STAT_W-1:0]    status;
    logic [CNT_OUT_W-1:0] cursor_position;
    logic [CNT_OUT_W-1:0] text_length;
    logic [CHAR_W-1:0]    char_out;
  } result_t;

endpackage

### hdl/cursor_text_buffer_unit.sv
// ----------------------------------------------------------------------------
// cursor_text_buffer_unit - line buffer with a cursor, kept as two stacks
// insert, cursor left/right, backspace and indexed read on two ram stacks
// ----------------------------------------------------------------------------
// results: insert, backspace, boundary cases and out-of-range reads give their
//   result in the cycle after the request; cursor moves and reads first do a
//   registered ram read, then the write-back or result in the wait state
// throughput: one request per cycle for insert/backspace while results are taken;
//   requests that read a stack ram hold off the next one until the read is done
// reset: rst clears both stack counts, the state machine and the result valid flag;
//   stack contents are left as they are, no clearing pass
module cursor_text_buffer_unit #(
  parameter int CAPACITY = ctb_pkg::CAPACITY_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  // request stream
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [ctb_pkg::IN_W-1:0]  s_tdata,  // command[2:0], char_in[10:3],
                                              // read_position[20:11], zero pad
  // result stream
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [ctb_pkg::OUT_W-1:0] m_tdata   // char_out[7:0], text_length[18:8],
                                              // cursor_position[29:19], status[31:30]
);

  import ctb_pkg::*;

  // widths that follow from the capacity
  localparam int AW = $clog2(CAPACITY);           // stack address
  localparam int CW = $clog2(CAPACITY + 1);       // stack count, holds CAPACITY
  localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;  // position arithmetic
  localparam int XW = (CW > CNT_OUT_W) ? CW : CNT_OUT_W; // output masking
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WAIT = 2'b10
  } state_t;

  // request fields
  logic [CMD_W-1:0]  cmd;
  logic [CHAR_W-1:0] char_in;
  logic [POS_W-1:0]  read_position;

  assign cmd           = s_tdata[2:0];
  assign char_in       = s_tdata[10:3];
  assign read_position = s_tdata[20:11];

  // control registers
  state_t            state, state_next;
  logic [CW-1:0]     left_count, left_count_next;
  logic [CW-1:0]     right_count, right_count_next;
  logic [CMD_W-1:0]  pend_cmd;      // command waiting on a ram read
  logic              pend_left;     // read command takes data from the left stack
  logic              pend_left_next;
  logic              out_valid;
  result_t           out_q;

  // ram ports
  logic              l_we, r_we;
  logic [AW-1:0]     l_waddr, r_waddr, l_raddr, r_raddr;
  logic [CHAR_W-1:0] l_wdata, r_wdata, l_rdata, r_rdata;

  // result formation
  logic              res_load;
  logic [STAT_W-1:0] res_status;
  logic [CHAR_W-1:0] res_char;
  logic [XW-1:0]     len_x, cur_x;
  result_t           res;

  logic              accept;
  logic [CW-1:0]     total;
  logic [PW-1:0]     pos_x, lc_x, rc_x, off, ridx;
  logic              in_left, in_right;

  assign accept   = s_tvalid && s_tready;
  // a new request only while idle and the result slot is free or draining
  assign s_tready = (state == S_IDLE) && (!out_valid || m_tready);

  assign total = left_count + right_count;

  // locate a text index: left stack holds text order, right stack is reversed
  assign pos_x    = PW'(read_position);
  assign lc_x     = PW'(left_count);
  assign rc_x     = PW'(right_count);
  assign off      = pos_x - lc_x;
  assign in_left  = pos_x < lc_x;
  assign in_right = !in_left && (off < rc_x);
  assign ridx     = rc_x - PW'(1) - off;

  always_comb begin
    state_next       = state;
    left_count_next  = left_count;
    right_count_next = right_count;
    pend_left_next   = pend_left;
    res_load         = 1'b0;
    res_status       = ST_DONE;
    res_char         = '0;
    l_we             = 1'b0;
    r_we             = 1'b0;
    l_waddr          = left_count[AW-1:0];
    r_waddr          = right_count[AW-1:0];
    l_wdata          = char_in;
    r_wdata          = l_rdata;
    l_raddr          = AW'(left_count - 1'b1);
    r_raddr          = AW'(right_count - 1'b1);

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_INSERT: begin
              res_load = 1'b1;
              if (total >= CAP_C) begin
                res_status = ST_FULL;
              end else begin
                l_we            = 1'b1;
                left_count_next = left_count + 1'b1;
              end
            end
            CMD_LEFT: begin
              if (left_count == '0) begin
                res_load   = 1'b1;
                res_status = ST_IGNORED;
              end else begin
                state_next = S_WAIT;  // top of left stack on its way
              end
            end
            CMD_RIGHT: begin
              if (right_count == '0) begin
                res_load   = 1'b1;
                res_status = ST_IGNORED;
              end else begin
                state_next = S_WAIT;
              end
            end
            CMD_BACK: begin
              res_load = 1'b1;
              if (left_count == '0) begin
                res_status = ST_IGNORED;
              end else begin
                left_count_next = left_count - 1'b1;
              end
            end
            CMD_READ: begin
              l_raddr        = AW'(pos_x);
              r_raddr        = AW'(ridx);
              pend_left_next = in_left;
              if (in_left || in_right) begin
                state_next = S_WAIT;
              end else begin
                res_load   = 1'b1;
                res_status = ST_RANGE;
              end
            end
            default: begin
              res_load   = 1'b1;
              res_status = ST_IGNORED;
            end
          endcase
        end
      end
      S_WAIT: begin
        // ram data is here: finish the move or the read
        state_next = S_IDLE;
        res_load   = 1'b1;
        case (pend_cmd)
          CMD_LEFT: begin
            r_we             = 1'b1;
            r_wdata          = l_rdata;
            left_count_next  = left_count - 1'b1;
            right_count_next = right_count + 1'b1;
          end
          CMD_RIGHT: begin
            l_we             = 1'b1;
            l_wdata          = r_rdata;
            right_count_next = right_count - 1'b1;
            left_count_next  = left_count + 1'b1;
          end
          default: begin
            res_char = pend_left ? l_rdata : r_rdata;
          end
        endcase
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // counts go out masked to the output field width
  always_comb begin
    len_x               = XW'(left_count_next + right_count_next);
    cur_x               = XW'(left_count_next);
    res.status          = res_status;
    res.cursor_position = cur_x[CNT_OUT_W-1:0];
    res.text_length     = len_x[CNT_OUT_W-1:0];
    res.char_out        = res_char;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      left_count  <= '0;
      right_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      left_count  <= left_count_next;
      right_count <= right_count_next;
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_cmd <= cmd;
    end
    pend_left <= pend_left_next;
    if (res_load) begin
      out_q <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_q;

  // left stack: text order, entry 0 is the first character
  ctb_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (CAPACITY)
  ) u_left_stack (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  // right stack: top entry is the character just right of the cursor
  ctb_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (CAPACITY)
  ) u_right_stack (
    .clk   (clk),
    .we    (r_we),
    .waddr (r_waddr),
    .wdata (r_wdata),
    .raddr (r_raddr),
    .rdata (r_rdata)
  );

  // stacks together never hold more than the capacity
  a_cap: assert property (@(posedge clk) disable iff (rst)
    ((CW + 1)'(left_count) + (CW + 1)'(right_count)) <= (CW + 1)'(CAPACITY))
    else $error("stack counts exceed capacity");

  // the result slot is empty while a ram read is pending
  a_wait_slot: assert property (@(posedge clk) disable iff (rst)
    (state == S_WAIT) |-> !out_valid)
    else $error("result slot busy during ram read");

  // a pending request always completes with a result in the next cycle
  a_wait_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_WAIT) |=> (out_valid && state == S_IDLE))
    else $error("pending request did not complete");

endmodule

### hdl/ctb_ram.sv
// ----------------------------------------------------------------------------
// ctb_ram - generic simple dual-port ram
// one write port, one read port, read data registered
// ----------------------------------------------------------------------------
module ctb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench - self-checking bench for cursor_text_buffer_unit
// drives edit requests (insert, cursor moves, backspace, indexed read and the
// spare codes) with random idling on both streams, keeps its own two-stack
// copy of the text to predict every result, and compares each result field
// by field in request order
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ctb_pkg::*;

  localparam int CAPACITY = CAPACITY_DEF;
  // run limit in clock cycles, several times the slowest legal run
  localparam int CYCLE_LIMIT = 1_000_000;
  // receiver hold-off used to back the block up
  localparam int LONG_HOLD = 200;
  // quiet cycles after the last result
  localparam int SETTLE_CYCLES = 20;
  localparam int RANDOM_REQUESTS = 200;
  // text length the fill test grows to
  localparam int FILL_LEVEL = 150;
  // command codes the block does not define
  localparam logic [CMD_W-1:0] CMD_SPARE[3] = '{3'd5, 3'd6, 3'd7};

  logic clk = 1'b0;
  logic rst = 1'b1;

  // request stream
  logic            s_tvalid = 1'b0;
  logic            s_tready;
  logic [IN_W-1:0] s_tdata = '0;  // command[2:0], char_in[10:3],
                                  // read_position[20:11], zero pad
  // result stream
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;      // char_out[7:0], text_length[18:8],
                                  // cursor_position[29:19], status[31:30]

  cursor_text_buffer_unit #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  // ---------------------------------------------------------------------------
  // text copy: characters left of the cursor in text order, characters right
  // of the cursor with the one next to the cursor on top
  // ---------------------------------------------------------------------------
  logic [CHAR_W-1:0] left_chars[CAPACITY];
  logic [CHAR_W-1:0] right_chars[CAPACITY];
  int left_len = 0;
  int right_len = 0;

  result_t pending_results[$];
  int error_count = 0;
  int cycle_count = 0;

  // idling controls shared by the sender and the receiver
  bit steady_mode = 1'b0;  // no idling on either side while set
  bit hold_req = 1'b0;     // asks the receiver for one long hold-off

  // ---------------------------------------------------------------------------
  // clock and reset
  // ---------------------------------------------------------------------------
  initial begin
    forever #5 clk = ~clk;
  end

  // run limit, a hung handshake ends here
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // edit prediction: applies one request to the text copy and returns the
  // result the block should give for it
  // ---------------------------------------------------------------------------
  function automatic result_t apply_edit(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch,
                                         logic [POS_W-1:0] pos);
    result_t r;
    int p;
    r = '0;
    r.status = ST_DONE;
    p = int'(pos);
    case (cmd)
      CMD_INSERT: begin
        // a full buffer drops the character
        if (left_len + right_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          left_chars[left_len] = ch;
          left_len++;
        end
      end
      CMD_LEFT: begin
        if (left_len == 0) begin
          r.status = ST_IGNORED;
        end else begin
          left_len--;
          right_chars[right_len] = left_chars[left_len];
          right_len++;
        end
      end
      CMD_RIGHT: begin
        if (right_len == 0) begin
          r.status = ST_IGNORED;
        end else begin
          right_len--;
          left_chars[left_len] = right_chars[right_len];
          left_len++;
        end
      end
      CMD_BACK: begin
        if (left_len == 0) r.status = ST_IGNORED;
        else left_len--;
      end
      CMD_READ: begin
        // index past the cursor counts down from the top of the right stack
        if (p < left_len) r.char_out = left_chars[p];
        else if (p - left_len < right_len) r.char_out = right_chars[right_len - 1 - (p - left_len)];
        else r.status = ST_RANGE;
      end
      default: r.status = ST_IGNORED;
    endcase
    r.text_length = CNT_OUT_W'(left_len + right_len);
    r.cursor_position = CNT_OUT_W'(left_len);
    return r;
  endfunction

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // sender: offers one request, waits for the handshake, then predicts it;
  // valid stays high into the next request when there is no gap
  // ---------------------------------------------------------------------------
  task automatic send_request(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch,
                              logic [POS_W-1:0] pos);
    int gap;
    gap = steady_mode ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {{(IN_W - CMD_W - CHAR_W - POS_W){1'b0}}, pos, ch, cmd};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(apply_edit(cmd, ch, pos));
  endtask

  // edit request with random don't-care fields
  task automatic send_edit(logic [CMD_W-1:0] cmd);
    send_request(cmd, CHAR_W'($urandom), POS_W'($urandom));
  endtask

  task automatic send_read(int pos);
    send_request(CMD_READ, CHAR_W'($urandom), POS_W'(pos));
  endtask

  // read index, mostly inside the text, some past its end
  function automatic int pick_read_pos();
    int len;
    len = left_len + right_len;
    if (len >= CAPACITY) return $urandom_range(0, CAPACITY - 1);
    if (len == 0 || $urandom_range(0, 7) == 0) return $urandom_range(len, CAPACITY - 1);
    return $urandom_range(0, len - 1);
  endfunction

  // ---------------------------------------------------------------------------
  // receiver: random stalls, stretches without stalls, and one long hold-off
  // on request
  // ---------------------------------------------------------------------------
  initial begin
    int stall_left;
    stall_left = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if (hold_req) begin
        m_tready <= 1'b0;
        stall_left = LONG_HOLD - 1;
        hold_req = 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (!steady_mode && $urandom_range(0, 2) == 0) stall_left = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result checker: each accepted result against the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic report_field(string name, int want, int got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    error_count++;
  endtask

  task automatic check_result(logic [OUT_W-1:0] data);
    result_t got;
    result_t want;
    got = result_t'(data);
    if (pending_results.size() == 0) begin
      $display("%0t: result with none expected, expected nothing, actual %h", $time, data);
      error_count++;
    end else begin
      want = pending_results.pop_front();
      if (got.char_out !== want.char_out)
        report_field("char_out", want.char_out, got.char_out);
      if (got.text_length !== want.text_length)
        report_field("text_length", want.text_length, got.text_length);
      if (got.cursor_position !== want.cursor_position)
        report_field("cursor_position", want.cursor_position, got.cursor_position);
      if (got.status !== want.status)
        report_field("status", want.status, got.status);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_result(m_tdata);
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // boundary cases on an empty and a short text, extreme characters and
  // indexes, every command and the spare codes
  task automatic test_directed();
    send_edit(CMD_LEFT);   // at text start
    send_edit(CMD_RIGHT);  // at text end
    send_edit(CMD_BACK);   // nothing to delete
    send_read(0);          // empty text
    send_read(CAPACITY - 1);
    foreach (CMD_SPARE[i]) send_edit(CMD_SPARE[i]);
    send_request(CMD_INSERT, 8'h00, POS_W'($urandom));
    send_request(CMD_INSERT, 8'hff, POS_W'($urandom));
    send_request(CMD_INSERT, 8'h5a, POS_W'($urandom));
    for (int i = 0; i < 4; i++) send_read(i);  // last one just past the end
    send_edit(CMD_LEFT);
    send_edit(CMD_LEFT);
    send_read(0);  // left of the cursor
    send_read(2);  // deep in the right stack
    send_edit(CMD_RIGHT);
    send_edit(CMD_BACK);
    send_read(1);
    send_edit(CMD_LEFT);
    send_edit(CMD_LEFT);  // cursor already at start
    send_edit(CMD_BACK);  // at start with text to the right
  endtask

  // grows the text with the cursor wandering, reads across the whole index
  // range, then empties it again
  task automatic test_fill_and_drain();
    while (left_len + right_len < FILL_LEVEL) begin
      case ($urandom_range(0, 9))
        0: send_edit(CMD_LEFT);
        1: send_read(pick_read_pos());
        default: send_request(CMD_INSERT, CHAR_W'($urandom), POS_W'($urandom));
      endcase
    end
    repeat (3) send_request(CMD_INSERT, CHAR_W'($urandom), POS_W'($urandom));
    send_read(0);
    send_read(CAPACITY - 1);
    repeat (8) send_read($urandom_range(0, CAPACITY - 1));
    send_edit(CMD_LEFT);
    send_request(CMD_INSERT, CHAR_W'($urandom), POS_W'($urandom));
    // cursor to the end, then delete everything
    while (right_len > 0) begin
      if ($urandom_range(0, 15) == 0) send_read(pick_read_pos());
      send_edit(CMD_RIGHT);
    end
    send_edit(CMD_RIGHT);
    while (left_len > 0) begin
      if ($urandom_range(0, 15) == 0) send_read(pick_read_pos());
      send_edit(CMD_BACK);
    end
    send_edit(CMD_BACK);
  endtask

  // receiver holds off for a long stretch while requests keep coming, so the
  // block backs up and stalls its input
  task automatic test_backpressure();
    steady_mode = 1'b1;
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) begin
      if (i % 3 == 2) send_read(pick_read_pos());
      else if (i % 5 == 4) send_edit(CMD_LEFT);
      else send_request(CMD_INSERT, CHAR_W'($urandom), POS_W'($urandom));
    end
    steady_mode = 1'b0;
  endtask

  // random edit sessions, text length kept moderate so the cursor moves and
  // reads cover both stacks
  task automatic test_random();
    int len;
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      // idle-free stretches now and then
      if (i % 50 == 0) steady_mode = ($urandom_range(0, 3) == 0);
      len = left_len + right_len;
      if ($urandom_range(0, 99) < (len < 200 ? 40 : 15)) begin
        send_request(CMD_INSERT, CHAR_W'($urandom), POS_W'($urandom));
      end else begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3:         send_edit(CMD_LEFT);
          4, 5, 6, 7:         send_edit(CMD_RIGHT);
          8, 9, 10, 11:       send_edit(CMD_BACK);
          12, 13, 14, 15, 16,
          17, 18:             send_read(pick_read_pos());
          default:            send_edit(CMD_SPARE[$urandom_range(0, 2)]);
        endcase
      end
    end
    steady_mode = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_fill_and_drain();
    test_backpressure();
    test_random();
    s_tvalid <= 1'b0;

    // all results in, then a quiet window for anything extra
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### files.f
hdl/ctb_pkg.sv
hdl/ctb_ram.sv
hdl/cursor_text_buffer_unit.sv
bench/testbench.sv
